@@ design/dlle_pkg.sv @@
`default_nettype none
package dlle_pkg;

  localparam int CMD_W          = 3;
  localparam int STAT_W         = 2;
  localparam int VAL_W          = 32;
  localparam int PTR_W          = 6;
  localparam int POOL_NODES_DEF = 32;

  localparam logic [PTR_W-1:0] NULL_PTR = 6'd63;

  localparam logic [CMD_W-1:0] CMD_FRONT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BACK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_AFTER   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BEFORE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CONCAT  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              accept;      // latch the input transfer, point cur at a head
    logic              walk_step;   // emit node value, follow next
    logic              walk_seg_b;  // concat: move cur to head of list B
    logic              search_step; // follow next
    logic              search_hit;  // capture target node and neighbours
    logic              alloc;       // pop free stack, set link points
    logic              link1;       // write new node, head/tail
    logic              link2;       // patch neighbours
    logic              del;         // unlink target, push it on free stack
    logic              emit_fin;    // load closing result
    logic [STAT_W-1:0] fin_status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] in_cmd;
    logic [CMD_W-1:0] cmd;
    logic             cur_null;
    logic             hit;
    logic             pool_empty;
    logic             slot_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/dlle_ram.sv @@
`default_nettype none
module dlle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/dlle_ctrl.sv @@
`default_nettype none
module dlle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dlle_pkg::dp_stat_t st,
  output dlle_pkg::ctrl_cmd_t     c
);
  import dlle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_LINK1  = 3'd4;
  localparam logic [2:0] S_LINK2  = 3'd5;
  localparam logic [2:0] S_DEL    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]        state, state_next;
  logic              seg, seg_next;      // 1: walking the last list
  logic [STAT_W-1:0] fin, fin_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    seg_next   = seg;
    fin_next   = fin;
    c          = '0;
    c.fin_status = fin;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          c.accept = 1'b1;
          case (st.in_cmd)
            CMD_FRONT, CMD_BACK: state_next = S_ALLOC;
            CMD_AFTER, CMD_BEFORE, CMD_DELETE: state_next = S_SEARCH;
            CMD_DISPLAY: begin
              seg_next   = 1'b1;
              state_next = S_WALK;
            end
            CMD_CONCAT: begin
              seg_next   = 1'b0;
              state_next = S_WALK;
            end
            default: begin
              fin_next   = ST_OK;
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_WALK: begin
        if (st.cur_null) begin
          if (!seg) begin
            c.walk_seg_b = 1'b1;
            seg_next     = 1'b1;
          end else if (st.slot_free) begin
            c.emit_fin   = 1'b1;
            c.fin_status = ST_OK;
            state_next   = S_IDLE;
          end
        end else if (st.slot_free) begin
          c.walk_step = 1'b1;
        end
      end
      S_SEARCH: begin
        if (st.cur_null) begin
          fin_next   = ST_NOT_FOUND;
          state_next = S_FIN;
        end else if (st.hit) begin
          c.search_hit = 1'b1;
          state_next   = (st.cmd == CMD_DELETE) ? S_DEL : S_ALLOC;
        end else begin
          c.search_step = 1'b1;
        end
      end
      S_ALLOC: begin
        if (st.pool_empty) begin
          fin_next   = ST_FULL;
          state_next = S_FIN;
        end else begin
          c.alloc    = 1'b1;
          state_next = S_LINK1;
        end
      end
      S_LINK1: begin
        c.link1    = 1'b1;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        c.link2    = 1'b1;
        fin_next   = ST_OK;
        state_next = S_FIN;
      end
      S_DEL: begin
        c.del      = 1'b1;
        fin_next   = ST_OK;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.slot_free) begin
          c.emit_fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg   <= 1'b0;
      fin   <= ST_OK;
    end else begin
      state <= state_next;
      seg   <= seg_next;
      fin   <= fin_next;
    end
  end

endmodule
`default_nettype wire

@@ design/dlle_dp.sv @@
`default_nettype none
module dlle_dp #(
  parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [dlle_pkg::CMD_W-1:0]     in_command,
  input  wire logic                           in_list_sel,
  input  wire logic [dlle_pkg::VAL_W-1:0]     in_target,
  input  wire logic [dlle_pkg::VAL_W-1:0]     in_new,
  input  wire dlle_pkg::ctrl_cmd_t            c,
  output dlle_pkg::dp_stat_t                  st,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dlle_pkg::STAT_W-1:0]    out_status,
  output logic                                out_has_value,
  output logic      [dlle_pkg::VAL_W-1:0]     out_value,
  output logic                                out_last
);
  import dlle_pkg::*;

  localparam int AW = $clog2(POOL_NODES);
  localparam logic [PTR_W-1:0] POOL_PTR = PTR_W'(POOL_NODES);

  function automatic logic is_node(input logic [PTR_W-1:0] p);
    is_node = (p < POOL_PTR);
  endfunction

  logic [CMD_W-1:0] cmd;
  logic             sel;
  logic [VAL_W-1:0] target, newval;
  logic [PTR_W-1:0] head [2];
  logic [PTR_W-1:0] tail [2];
  logic [PTR_W-1:0] cur, cur_next;
  logic [PTR_W-1:0] tgt, tprv, tnxt, nn, lp, lq;
  logic [PTR_W-1:0] fc, fc_next;
  logic [POOL_NODES-1:0] fs_vld;
  logic             top_vld;
  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    fs_raddr, fs_rdata;
  logic [PTR_W-1:0] top_node;
  logic             push;

  logic [VAL_W-1:0] rd_data;
  logic [PTR_W-1:0] rd_next, rd_prev;

  logic             nx_we, pv_we;
  logic [PTR_W-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;

  // node pointer that cur moves to this cycle; read address of the node memories
  always_comb begin
    cur_next = cur;
    if (c.accept) begin
      cur_next = (in_command == CMD_CONCAT) ? head[0] : head[in_list_sel];
    end else if (c.walk_seg_b) begin
      cur_next = head[1];
    end else if (c.walk_step || c.search_step) begin
      cur_next = rd_next;
    end
  end

  assign push    = c.del && (fc < POOL_PTR);
  assign fc_next = c.alloc ? fc - PTR_W'(1) : (push ? fc + PTR_W'(1) : fc);
  assign fs_raddr = AW'(fc_next - PTR_W'(1));
  // untouched stack entries hold their reset contents
  assign top_node = top_vld ? PTR_W'(fs_rdata) : PTR_W'(POOL_NODES - 1) - PTR_W'(top_addr);

  always_comb begin
    nx_we = 1'b0; nx_waddr = nn; nx_wdata = lq;
    pv_we = 1'b0; pv_waddr = nn; pv_wdata = lp;
    if (c.link1) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (c.link2) begin
      nx_we = is_node(lp); nx_waddr = lp; nx_wdata = nn;
      pv_we = is_node(lq); pv_waddr = lq; pv_wdata = nn;
    end else if (c.del) begin
      nx_we = is_node(tprv); nx_waddr = tprv; nx_wdata = tnxt;
      pv_we = is_node(tnxt); pv_waddr = tnxt; pv_wdata = tprv;
    end
  end

  dlle_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_data (
    .clk(clk), .we(c.link1), .waddr(nn[AW-1:0]), .wdata(newval),
    .raddr(cur_next[AW-1:0]), .rdata(rd_data)
  );

  dlle_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr[AW-1:0]), .wdata(nx_wdata),
    .raddr(cur_next[AW-1:0]), .rdata(rd_next)
  );

  dlle_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr[AW-1:0]), .wdata(pv_wdata),
    .raddr(cur_next[AW-1:0]), .rdata(rd_prev)
  );

  dlle_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_free (
    .clk(clk), .we(push), .waddr(fc[AW-1:0]), .wdata(tgt[AW-1:0]),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign st.in_cmd     = in_command;
  assign st.cmd        = cmd;
  assign st.cur_null   = !is_node(cur);
  assign st.hit        = (rd_data == target);
  assign st.pool_empty = (fc == '0);
  assign st.slot_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    top_vld  <= fs_vld[fs_raddr];
    top_addr <= fs_raddr;
    cur      <= cur_next;
    if (c.accept) begin
      cmd    <= in_command;
      sel    <= in_list_sel;
      target <= in_target;
      newval <= in_new;
    end
    if (c.search_hit) begin
      tgt  <= cur;
      tprv <= rd_prev;
      tnxt <= rd_next;
    end
    if (c.alloc) begin
      nn <= top_node;
      case (cmd)
        CMD_FRONT: begin lp <= NULL_PTR;  lq <= head[sel]; end
        CMD_BACK:  begin lp <= tail[sel]; lq <= NULL_PTR;  end
        CMD_AFTER: begin lp <= tgt;       lq <= tnxt;      end
        default:   begin lp <= tprv;      lq <= tgt;       end
      endcase
    end
    if (c.walk_step) begin
      out_status    <= ST_OK;
      out_has_value <= 1'b1;
      out_value     <= rd_data;
      out_last      <= 1'b0;
    end else if (c.emit_fin) begin
      out_status    <= c.fin_status;
      out_has_value <= 1'b0;
      out_value     <= '0;
      out_last      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head[0]   <= NULL_PTR;
      head[1]   <= NULL_PTR;
      tail[0]   <= NULL_PTR;
      tail[1]   <= NULL_PTR;
      fc        <= POOL_PTR;
      fs_vld    <= '0;
      out_valid <= 1'b0;
    end else begin
      fc <= fc_next;
      if (push) begin
        fs_vld[fc[AW-1:0]] <= 1'b1;
      end
      if (c.link1) begin
        if (!is_node(lp)) head[sel] <= nn;
        if (!is_node(lq)) tail[sel] <= nn;
      end
      if (c.del) begin
        if (!is_node(tprv)) head[sel] <= tnxt;
        if (!is_node(tnxt)) tail[sel] <= tprv;
      end
      if (c.walk_step || c.emit_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/dual_linked_list_engine_top.sv @@
`default_nettype none
// Channel  Dir  Group                   Contents
// command  in   s_tvalid/s_tready       s_tuser: command[2:0] list_sel[3]
//                                       s_tdata: target_value[31:0] new_value[63:32]
// result   out  m_tvalid/m_tready       m_tuser: status[1:0] has_value[2]
//                                       m_tdata: item_value[31:0], m_tlast: last
//
// One command at a time. Front/back insert allocates a node, writes it and then patches
// its neighbours; insert after/before first searches for the target (a missing target
// closes with not-found), and delete searches and then unlinks. Display walks one list;
// concat walks list A, then hops to list B. Walks and searches follow one node per cycle
// through the node memories, a walk only while the output is free. Reset empties both
// lists and refills the free stack at once, no sweep. A stalled result holds in the
// output register; the walk and the closing transfer pause until it moves.
module dual_linked_list_engine_top #(
  parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // target_value[31:0], new_value[63:32]
  input  wire logic [3:0]  s_tuser,  // command[2:0], list_sel[3]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,  // item_value[31:0]
  output logic      [2:0]  m_tuser,  // status[1:0], has_value[2]
  output logic             m_tlast
);
  import dlle_pkg::*;

  ctrl_cmd_t c;
  dp_stat_t  st;

  // controller: sequencing of search, allocation, linking and walks
  dlle_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .st(st), .c(c)
  );

  // datapath: node memories, heads/tails, free stack, result register
  dlle_dp #(.POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst(rst),
    .in_command(s_tuser[2:0]), .in_list_sel(s_tuser[3]),
    .in_target(s_tdata[31:0]), .in_new(s_tdata[63:32]),
    .c(c), .st(st),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(m_tuser[1:0]), .out_has_value(m_tuser[2]),
    .out_value(m_tdata), .out_last(m_tlast)
  );

endmodule
`default_nettype wire
